@@ hw/rtl/mbd_pkg.sv @@
`timescale 1ns / 1ps

package mbd_pkg;

    // One color channel and the sum of a horizontal pair of channels.
    localparam int CHAN_W   = 8;
    localparam int PAIR_W   = CHAN_W + 1;
    localparam int NUM_CHAN = 4;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = CFG_INDEX_W'(1);

    // Height limit and the counters that follow from it.
    localparam int MAX_SOURCE_HEIGHT = 4096;
    localparam int HEIGHT_W          = 13;
    localparam int ROW_CNT_W         = 12;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] texel_t;
    typedef logic [NUM_CHAN-1:0][PAIR_W-1:0] pair_t;

endpackage

@@ hw/rtl/mbd_if.sv @@
`timescale 1ns / 1ps

interface mbd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mbd_pkg::CFG_INDEX_W-1:0]    index;
    logic [mbd_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface mbd_texel_if;
    logic                           valid;
    logic                           ready;
    logic [mbd_pkg::CHAN_W-1:0]     red_in;
    logic [mbd_pkg::CHAN_W-1:0]     green_in;
    logic [mbd_pkg::CHAN_W-1:0]     blue_in;
    logic [mbd_pkg::CHAN_W-1:0]     alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input alpha_in, output ready);
endinterface

interface mbd_result_if;
    logic                           valid;
    logic                           ready;
    logic [mbd_pkg::CHAN_W-1:0]     red_out;
    logic [mbd_pkg::CHAN_W-1:0]     green_out;
    logic [mbd_pkg::CHAN_W-1:0]     blue_out;
    logic [mbd_pkg::CHAN_W-1:0]     alpha_out;
    logic                           level_done;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, output level_done, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input alpha_out, input level_done, output ready);
endinterface

@@ hw/rtl/mbd_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
module mbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/mipmap_box_downsample_top.sv @@
`timescale 1ns / 1ps

// A result beat leaves through stage 1 and then the output register after the odd-row texel that closes it.
// Throughput: one texel beat per cycle while results are taken; each beat does at most one row-buffer
// access (a write on even rows, a read on odd rows), so the single RAM never limits rate.
// Reset (rst_n, asynchronous, active low) sets width and height to 2 and clears the
// position counters, the held left texel and the pipeline valids; the row buffer is not
// cleared, since every odd row reads only entries its even row wrote in the same pass.
module mipmap_box_downsample_top #(
    parameter int MAX_SOURCE_WIDTH = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    mbd_cfg_if.sink       cfg,
    mbd_texel_if.sink     texel,
    mbd_result_if.source  result
);

    // Column counter covers one source row, the effective width also holds the limit
    // itself, and the row buffer keeps one entry per output column.
    localparam int COL_W     = $clog2(MAX_SOURCE_WIDTH);
    localparam int EW        = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int ROW_DEPTH = MAX_SOURCE_WIDTH / 2;
    localparam int AW        = $clog2(ROW_DEPTH);
    localparam int RAM_W     = mbd_pkg::NUM_CHAN * mbd_pkg::PAIR_W;

    // Configuration, already clamped to the supported limits.
    logic [EW-1:0]                  eff_w_reg;
    logic [mbd_pkg::HEIGHT_W-1:0]   eff_h_reg;

    // Position of the next source texel and the even-column texel awaiting its partner.
    logic [COL_W-1:0]               col_reg;
    logic [mbd_pkg::ROW_CNT_W-1:0]  row_reg;
    mbd_pkg::texel_t                left_reg;

    // Stage 1: the row buffer read is in flight, the current pair sums wait beside it.
    logic                           s1_valid_reg;
    mbd_pkg::pair_t                 s1_pair_reg;
    logic                           s1_done_reg;

    // Output register.
    logic                           out_valid_reg;
    mbd_pkg::texel_t                out_texel_reg;
    logic                           out_done_reg;

    logic                           cfg_acc;
    logic                           texel_acc;
    logic                           s1_adv;
    mbd_pkg::texel_t                cur_texel;
    mbd_pkg::pair_t                 pair_sum;
    mbd_pkg::pair_t                 above_sum;
    mbd_pkg::texel_t                avg_texel;
    logic [RAM_W-1:0]               ram_rd_data;
    logic [EW-1:0]                  out_w;
    logic [mbd_pkg::HEIGHT_W-1:0]   out_h;
    logic [EW-1:0]                  ocol;
    logic [mbd_pkg::HEIGHT_W-1:0]   orow;
    logic                           pair_hit;
    logic                           ram_wr_en;
    logic                           ram_rd_en;
    logic                           block_done;
    logic                           col_last;
    logic                           row_last;

    // Configuration writes are always taken, unchecked; the user keeps the block idle whenever they arrive.
    assign cfg.ready = 1'b1;
    assign cfg_acc   = cfg.valid & cfg.ready;

    // The output register drains when empty or taken; stage 1 moves whenever it does.
    // A new texel is taken unless stage 1 holds a beat that cannot move on.
    assign s1_adv      = !out_valid_reg || result.ready;
    assign texel.ready = !s1_valid_reg || s1_adv;
    assign texel_acc   = texel.valid & texel.ready;

    assign cur_texel = {texel.alpha_in, texel.blue_in, texel.green_in, texel.red_in};

    // Horizontal pair sums of the held left texel and the arriving right texel.
    always_comb
    begin
        for (int c = 0; c < mbd_pkg::NUM_CHAN; c++)
        begin
            pair_sum[c] = {1'b0, left_reg[c]} + {1'b0, cur_texel[c]};
        end
    end

    // The texel closes a horizontal pair on odd columns, inside the reduced level.
    // An unpaired last column or row falls outside and is dropped.
    assign out_w      = eff_w_reg >> 1;
    assign out_h      = eff_h_reg >> 1;
    assign ocol       = EW'(col_reg >> 1);
    assign orow       = mbd_pkg::HEIGHT_W'(row_reg >> 1);
    assign pair_hit   = col_reg[0] && (ocol < out_w) && (orow < out_h);
    assign block_done = (ocol + EW'(1) == out_w) && (orow + mbd_pkg::HEIGHT_W'(1) == out_h);

    // Even rows store their pair sums; odd rows fetch them back through the registered read port for the add.
    assign ram_wr_en = texel_acc && pair_hit && !row_reg[0];
    assign ram_rd_en = texel_acc && pair_hit && row_reg[0];

    assign col_last = (EW'(col_reg) + EW'(1)) >= eff_w_reg;
    assign row_last = (mbd_pkg::HEIGHT_W'(row_reg) + mbd_pkg::HEIGHT_W'(1)) >= eff_h_reg;

    mbd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ROW_DEPTH)
    ) u_row_buf (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (AW'(col_reg >> 1)),
        .wr_data (pair_sum),
        .rd_en   (ram_rd_en),
        .rd_addr (AW'(col_reg >> 1)),
        .rd_data (ram_rd_data)
    );

    // Vertical add of the stored and current pair sums; dropping two bits floors the mean.
    assign above_sum = ram_rd_data;

    always_comb
    begin
        for (int c = 0; c < mbd_pkg::NUM_CHAN; c++)
        begin
            avg_texel[c] = mbd_pkg::CHAN_W'(
                ({1'b0, above_sum[c]} + {1'b0, s1_pair_reg[c]}) >> 2);
        end
    end

    // Control state, counters and the held texel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg     <= EW'(2);
            eff_h_reg     <= mbd_pkg::HEIGHT_W'(2);
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_acc)
            begin
                if (cfg.index == mbd_pkg::REG_SOURCE_WIDTH)
                begin
                    if (int'(cfg.data) > MAX_SOURCE_WIDTH)
                    begin
                        eff_w_reg <= EW'(MAX_SOURCE_WIDTH);
                    end
                    else
                    begin
                        eff_w_reg <= EW'(cfg.data);
                    end
                    col_reg <= '0;
                    row_reg <= '0;
                end
                else if (cfg.index == mbd_pkg::REG_SOURCE_HEIGHT)
                begin
                    if (int'(cfg.data) > mbd_pkg::MAX_SOURCE_HEIGHT)
                    begin
                        eff_h_reg <= mbd_pkg::HEIGHT_W'(mbd_pkg::MAX_SOURCE_HEIGHT);
                    end
                    else
                    begin
                        eff_h_reg <= mbd_pkg::HEIGHT_W'(cfg.data);
                    end
                    col_reg <= '0;
                    row_reg <= '0;
                end
            end
            else if (texel_acc)
            begin
                if (!col_reg[0])
                begin
                    left_reg <= cur_texel;
                end
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_last ? '0 : row_reg + mbd_pkg::ROW_CNT_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end

            if (ram_rd_en)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ram_rd_en)
        begin
            s1_pair_reg <= pair_sum;
            s1_done_reg <= block_done;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_texel_reg <= avg_texel;
            out_done_reg  <= s1_done_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.red_out    = out_texel_reg[0];
    assign result.green_out  = out_texel_reg[1];
    assign result.blue_out   = out_texel_reg[2];
    assign result.alpha_out  = out_texel_reg[3];
    assign result.level_done = out_done_reg;

    // A beat whose buffer read is in flight is never dropped while the output stalls.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("stage 1 beat lost during output stall");

    // The row buffer is only read on odd rows and written on even rows, never both at once.
    a_rd_odd_row: assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd_en |-> (row_reg[0] && !ram_wr_en))
        else $error("row buffer read outside an odd row");

    // A new read never overruns a stage 1 beat that cannot move.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd_en |-> (!s1_valid_reg || s1_adv))
        else $error("stage 1 overrun");

    // The column counter stays inside the source row.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg == '0) || (EW'(col_reg) < eff_w_reg))
        else $error("column counter past source width");

    // A rising result valid always comes from a beat that stage 1 held.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result beat without a stage 1 beat");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the 2x2 box-filter mip level reducer. Source texels go in
// one beat at a time in raster order. A predictor in this module follows the same
// row-pair arithmetic as the block and queues every reduced texel it expects. Each
// result beat is checked against the oldest queued texel.
module testbench;

    localparam int MAX_WIDTH      = 4096;
    localparam int ROW_ENTRIES    = MAX_WIDTH / 2;
    localparam int SETTLE_CYCLES  = 8;      // Margin for the block's pipeline to drain.
    localparam int WATCHDOG_LIMIT = 2000;   // Cycles in a row with no beat on any channel.

    // The block defines only two registers. These indexes must be accepted and ignored.
    localparam logic [mbd_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = mbd_pkg::CFG_INDEX_W'(2);
    localparam logic [mbd_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = mbd_pkg::CFG_INDEX_W'(3);

    localparam string CHANNEL_NAME [mbd_pkg::NUM_CHAN] = '{"red_out", "green_out",
                                                           "blue_out", "alpha_out"};

    // One reduced texel as the predictor expects it.
    typedef struct packed {
        mbd_pkg::texel_t color;
        logic            last;
    } box_texel_t;

    logic clk;
    logic rst_n;

    mbd_cfg_if    cfg_bus ();
    mbd_texel_if  texel_bus ();
    mbd_result_if result_bus ();

    mipmap_box_downsample_top #(
        .MAX_SOURCE_WIDTH(MAX_WIDTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .texel  (texel_bus),
        .result (result_bus)
    );

    // Predictor state. It mirrors the block's registers, its position in the source
    // level, the even-column texel that waits for its right neighbor and the row of
    // horizontal pair sums left behind by the last even row.
    logic [mbd_pkg::CFG_DATA_W-1:0] level_width;
    logic [mbd_pkg::CFG_DATA_W-1:0] level_height;
    int unsigned                    column_pos;
    int unsigned                    row_pos;
    mbd_pkg::texel_t                held_left;
    mbd_pkg::pair_t                 pair_row_sums [ROW_ENTRIES];
    box_texel_t                     expected_boxes [$];

    // Idle rates, in percent of cycles, for the texel sender and the result receiver.
    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;

    int unsigned errors;
    int unsigned texels_sent;
    int unsigned boxes_checked;
    int unsigned registers_written;
    int unsigned quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // A register write lands and, for the two real registers, restarts the pass.
    function automatic void apply_register(input logic [mbd_pkg::CFG_INDEX_W-1:0] index,
                                           input logic [mbd_pkg::CFG_DATA_W-1:0] data);
        if (index == mbd_pkg::REG_SOURCE_WIDTH)
        begin
            level_width = data;
            column_pos  = 0;
            row_pos     = 0;
        end
        else if (index == mbd_pkg::REG_SOURCE_HEIGHT)
        begin
            level_height = data;
            column_pos   = 0;
            row_pos      = 0;
        end
    endfunction

    // Takes one accepted source texel. Even columns are held; odd columns form a
    // horizontal pair. On even rows the pair sum is stored, on odd rows it is added to
    // the stored sum above it and the floor of the mean of the four texels is queued.
    // Columns and rows past the last full pair are consumed without effect.
    function automatic void absorb_texel(input mbd_pkg::texel_t px);
        int unsigned              eff_width;
        int unsigned              eff_height;
        int unsigned              pair_col;
        int unsigned              pair_row;
        mbd_pkg::pair_t           pair;
        logic [mbd_pkg::PAIR_W:0] four_sum;
        box_texel_t               box;

        eff_width  = (level_width > MAX_WIDTH) ? MAX_WIDTH : level_width;
        eff_height = (level_height > mbd_pkg::MAX_SOURCE_HEIGHT) ?
                     mbd_pkg::MAX_SOURCE_HEIGHT : level_height;
        pair_col   = column_pos / 2;
        pair_row   = row_pos / 2;

        if (column_pos[0] == 1'b0)
        begin
            held_left = px;
        end
        else if (pair_col < eff_width / 2 && pair_row < eff_height / 2)
        begin
            for (int c = 0; c < mbd_pkg::NUM_CHAN; c++)
            begin
                pair[c] = {1'b0, held_left[c]} + {1'b0, px[c]};
            end
            if (row_pos[0] == 1'b0)
            begin
                pair_row_sums[pair_col] = pair;
            end
            else
            begin
                for (int c = 0; c < mbd_pkg::NUM_CHAN; c++)
                begin
                    four_sum     = {1'b0, pair_row_sums[pair_col][c]} + {1'b0, pair[c]};
                    box.color[c] = four_sum[mbd_pkg::PAIR_W:2];
                end
                box.last = (pair_col + 1 == eff_width / 2) && (pair_row + 1 == eff_height / 2);
                expected_boxes.push_back(box);
            end
        end

        // Advance the raster position; the pass wraps after its last texel.
        if (column_pos + 1 >= eff_width)
        begin
            column_pos = 0;
            row_pos    = (row_pos + 1 >= eff_height) ? 0 : row_pos + 1;
        end
        else
        begin
            column_pos = column_pos + 1;
        end
    endfunction

    function automatic void check_box();
        box_texel_t      want;
        mbd_pkg::texel_t got;

        if (expected_boxes.size() == 0)
        begin
            errors++;
            $display("%0t: result beat arrived with no reduced texel expected", $time);
            return;
        end
        want = expected_boxes.pop_front();
        got  = {result_bus.alpha_out, result_bus.blue_out, result_bus.green_out,
                result_bus.red_out};
        boxes_checked++;
        for (int c = 0; c < mbd_pkg::NUM_CHAN; c++)
        begin
            if (got[c] !== want.color[c])
            begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, CHANNEL_NAME[c],
                         want.color[c], got[c]);
            end
        end
        if (result_bus.level_done !== want.last)
        begin
            errors++;
            $display("%0t: level_done expected %0b, got %0b", $time, want.last,
                     result_bus.level_done);
        end
    endfunction

    // Every beat is seen at the rising edge, before the block updates anything. The
    // configuration and texel channels are never busy in the same cycle, and a result
    // leaves the block well after the texel that closes it, so this order is safe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                apply_register(cfg_bus.index, cfg_bus.data);
            end
            if (texel_bus.valid && texel_bus.ready)
            begin
                absorb_texel({texel_bus.alpha_in, texel_bus.blue_in, texel_bus.green_in,
                              texel_bus.red_in});
            end
            if (result_bus.valid && result_bus.ready)
            begin
                check_box();
            end
        end
    end

    // The watchdog ends a run that has stopped moving, with no beat on any channel.
    always @(posedge clk)
    begin
        if ((cfg_bus.valid && cfg_bus.ready) || (texel_bus.valid && texel_bus.ready) ||
            (result_bus.valid && result_bus.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles, %0d reduced texels still expected",
                     quiet_cycles, expected_boxes.size());
            $display("mipmap_box_downsample_top regression: fail");
            $finish;
        end
    end

    // The receiver stalls at random, at the rate that the current phase sets.
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    function automatic mbd_pkg::texel_t rgba(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic [7:0] a);
        return {a, b, g, r};
    endfunction

    // Random bytes, with a fair share of all-zero and all-one channels so that the
    // sums reach both ends of their range.
    function automatic mbd_pkg::texel_t noisy_texel();
        mbd_pkg::texel_t px;

        px = mbd_pkg::texel_t'($urandom());
        for (int c = 0; c < mbd_pkg::NUM_CHAN; c++)
        begin
            case ($urandom_range(9))
                0: px[c] = '0;
                1: px[c] = '1;
                default: ;
            endcase
        end
        return px;
    endfunction

    // The driving tasks below are entered and left right after a falling edge, and
    // none of them touches a signal in the step that it is entered in if the caller
    // may already have touched it there.

    // Sends one texel beat, after a random idle gap.
    task automatic push_texel(input mbd_pkg::texel_t px);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            texel_bus.valid <= 1'b0;
            @(negedge clk);
        end
        texel_bus.valid    <= 1'b1;
        texel_bus.red_in   <= px[0];
        texel_bus.green_in <= px[1];
        texel_bus.blue_in  <= px[2];
        texel_bus.alpha_in <= px[3];
        @(posedge clk);
        while (!texel_bus.ready) @(posedge clk);
        texels_sent++;
        @(negedge clk);
    endtask

    // Holds the sender until every expected reduced texel has come, then lets the
    // block settle, since even-row texels may still be in flight with no result.
    task automatic wait_for_results();
        texel_bus.valid <= 1'b0;
        while (expected_boxes.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes one register. The caller makes sure that the block is idle.
    task automatic write_register(input logic [mbd_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [mbd_pkg::CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        registers_written++;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_level(input int unsigned width, input int unsigned height);
        wait_for_results();
        write_register(mbd_pkg::REG_SOURCE_WIDTH, mbd_pkg::CFG_DATA_W'(width));
        write_register(mbd_pkg::REG_SOURCE_HEIGHT, mbd_pkg::CFG_DATA_W'(height));
    endtask

    // Streams random texels; before texel number pause_at the sender waits until
    // every expected result is back.
    task automatic stream_texels(input int unsigned count, input int unsigned pause_at);
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n == pause_at)
            begin
                wait_for_results();
            end
            push_texel(noisy_texel());
        end
    endtask

    // Reset leaves a 2x2 level configured, so these passes run without a register
    // write. The passes follow each other with no write in between, so the wrap at
    // the end of a pass is checked too. The sums cover all-zero and all-one texels,
    // a fraction that must be dropped, and alternating bit patterns.
    task automatic test_extreme_channels();
        repeat (4) push_texel(rgba(8'h00, 8'h00, 8'h00, 8'h00));
        repeat (4) push_texel(rgba(8'hff, 8'hff, 8'hff, 8'hff));
        push_texel(rgba(8'hff, 8'h00, 8'h03, 8'h01));
        push_texel(rgba(8'hff, 8'h00, 8'h00, 8'h01));
        push_texel(rgba(8'hff, 8'h00, 8'h00, 8'h01));
        push_texel(rgba(8'hfe, 8'h00, 8'h00, 8'h00));
        push_texel(rgba(8'h55, 8'haa, 8'h0f, 8'hf0));
        push_texel(rgba(8'haa, 8'h55, 8'hf0, 8'h0f));
        push_texel(rgba(8'haa, 8'h55, 8'hf0, 8'h0f));
        push_texel(rgba(8'h55, 8'haa, 8'h0f, 8'hf0));
    endtask

    // A 3x3 level reduces to a single texel; the last column and row have no partner.
    task automatic test_odd_edges();
        set_level(3, 3);
        stream_texels(9, 9);
    endtask

    // Levels less than two texels wide or high reduce to nothing. Their texels are
    // still consumed and counted.
    task automatic test_thin_levels();
        set_level(0, 2);
        stream_texels(2, 2);
        set_level(2, 0);
        stream_texels(2, 2);
        set_level(1, 3);
        stream_texels(3, 3);
    endtask

    // The spare register indexes must leave the position alone, while a real register
    // write in the middle of a pass must restart it.
    task automatic test_register_writes();
        set_level(4, 2);
        stream_texels(4, 4);
        wait_for_results();
        write_register(REG_SPARE_LO, mbd_pkg::CFG_DATA_W'($urandom_range(8191)));
        write_register(REG_SPARE_HI, mbd_pkg::CFG_DATA_W'($urandom_range(8191)));
        stream_texels(4, 4);
        stream_texels(5, 5);
        set_level(6, 2);
        stream_texels(12, 12);
    endtask

    // Random levels with random content, mostly small and complete. Some passes stop
    // early, some reuse the previous setting without a write and so continue where the
    // last pass ended, and some pause the sender partway until all results are back.
    // Texels of levels that reduce to nothing are not counted toward the target.
    task automatic test_random_levels(input int unsigned target);
        int unsigned counted;
        int unsigned width;
        int unsigned height;
        int unsigned count;
        int unsigned pause_at;
        bit          fresh;

        counted = 0;
        fresh   = 1'b1;
        width   = 2;
        height  = 2;
        while (counted < target)
        begin
            if (fresh || $urandom_range(3) != 0)
            begin
                case ($urandom_range(19))
                    0:       width = $urandom_range(1);
                    1:       width = $urandom_range(40, 11);
                    default: width = $urandom_range(10, 2);
                endcase
                height = ($urandom_range(15) == 0) ? $urandom_range(1) : $urandom_range(6, 2);
                set_level(width, height);
                fresh = 1'b0;
            end
            if (width < 2 || height < 2)
            begin
                count = $urandom_range(6, 1);
            end
            else
            begin
                count = width * height;
                if ($urandom_range(9) == 0)
                begin
                    count = $urandom_range(count - 1, 1);
                end
                counted += count;
            end
            pause_at = ($urandom_range(9) == 0) ? $urandom_range(count - 1) : count;
            stream_texels(count, pause_at);
        end
    endtask

    // The widest and the tallest settings. Each writes one register with every bit
    // set, so that register saturates at its limit. A short stretch of each pass runs before the
    // next write restarts the position; the tall one yields results on its way.
    task automatic test_largest_levels();
        set_level(8191, 2);
        stream_texels(24, 24);
        set_level(2, 8191);
        stream_texels(24, 12);
    endtask

    initial
    begin
        errors            = 0;
        texels_sent       = 0;
        boxes_checked     = 0;
        registers_written = 0;
        quiet_cycles      = 0;
        sender_idle_pct   = 37;
        receiver_idle_pct = 50;

        // Predictor state after reset.
        level_width  = mbd_pkg::CFG_DATA_W'(2);
        level_height = mbd_pkg::CFG_DATA_W'(2);
        column_pos   = 0;
        row_pos      = 0;
        held_left    = '0;

        rst_n              = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = mbd_pkg::REG_SOURCE_WIDTH;
        cfg_bus.data       = '0;
        texel_bus.valid    = 1'b0;
        texel_bus.red_in   = '0;
        texel_bus.green_in = '0;
        texel_bus.blue_in  = '0;
        texel_bus.alpha_in = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase one: the sender idles less often than the receiver.
        test_extreme_channels();
        test_odd_edges();
        test_thin_levels();
        test_random_levels(110);

        // Phase two: the other way round.
        sender_idle_pct   = 50;
        receiver_idle_pct = 37;
        test_register_writes();
        test_random_levels(110);

        // Phase three: both sides run flat out.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_levels(110);
        test_largest_levels();

        wait_for_results();

        $display("Sent %0d source texels and %0d register writes over square, odd, thin,",
                 texels_sent, registers_written);
        $display("partial and saturated levels; checked %0d reduced texels, %0d mismatches.",
                 boxes_checked, errors);
        if (errors == 0)
        begin
            $display("mipmap_box_downsample_top regression: pass");
        end
        else
        begin
            $display("mipmap_box_downsample_top regression: fail");
        end
        $finish;
    end

endmodule
